FILE: sv/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

FILE: sv/fcalc_pkg.sv
// Package: key codes, field widths and power-of-ten table for the calculator.
`timescale 1ns / 1ps
package fcalc_pkg;
  localparam int DISPLAY_CHARS_DEF = 12;
  localparam int FUNC_W = 3;
  localparam int DIGIT_W = 4;
  localparam int DVAL_W = 41;
  localparam int DLEN_W = 4;
  localparam int ACC_W = 32;
  localparam int OP_W = 3;

  localparam logic [FUNC_W-1:0] KEY_DIGIT  = 3'd0;
  localparam logic [FUNC_W-1:0] KEY_ADD    = 3'd1;
  localparam logic [FUNC_W-1:0] KEY_SUB    = 3'd2;
  localparam logic [FUNC_W-1:0] KEY_MUL    = 3'd3;
  localparam logic [FUNC_W-1:0] KEY_DIV    = 3'd4;
  localparam logic [FUNC_W-1:0] KEY_EQUALS = 3'd5;
  localparam logic [FUNC_W-1:0] KEY_CLEAR  = 3'd6;
  localparam logic [OP_W-1:0]   OP_NONE    = 3'd0;

  function automatic logic [ACC_W-1:0] pow10(input logic [3:0] k);
    logic [ACC_W-1:0] r;
    case (k)
      4'd1:    r = 32'd10;
      4'd2:    r = 32'd100;
      4'd3:    r = 32'd1000;
      4'd4:    r = 32'd10000;
      4'd5:    r = 32'd100000;
      4'd6:    r = 32'd1000000;
      4'd7:    r = 32'd10000000;
      4'd8:    r = 32'd100000000;
      4'd9:    r = 32'd1000000000;
      default: r = 32'd1;
    endcase
    return r;
  endfunction
endpackage

FILE: sv/four_function_calculator_keypad.sv
// Four-function calculator keypad: key decoding, serial multiply/divide, display.
// Usage:
//   Input channel (in_valid/in_stall) carries one keypress: func and digit.
//   Output channel (out_valid/out_stall) carries one result per keypress:
//   display value and length, accumulator and pending operator after the key.
//   One keypress is processed at a time; in_stall is high while it is at work.
// Sequence:
//   Digit, clear and ignored keys pass from accept to the output stage.
//   Operator/equals keys: add, subtract, plain load or divide by zero go
//   through the digit count of the accumulator; multiply and divide first
//   run the shift-add multiplier or restoring divider (one bit per cycle
//   over 32 bits), then the digit count (one power of ten per cycle).
//   The next keypress is taken once the result reaches the output register.
// Reset: synchronous rst clears display to 0 (length 1), accumulator to 0,
//   no pending operator, fresh entry set, output empty.
// Stall: a result waits in the output register while out_stall is high; the
//   next keypress may be taken meanwhile, and its result waits until free.
`timescale 1ns / 1ps
module four_function_calculator_keypad #(
  parameter int DISPLAY_CHARS = fcalc_pkg::DISPLAY_CHARS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [fcalc_pkg::FUNC_W-1:0]          func,
  input  logic [fcalc_pkg::DIGIT_W-1:0]         digit,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [fcalc_pkg::DVAL_W-1:0]   display_value,
  output logic [fcalc_pkg::DLEN_W-1:0]          display_length,
  output logic signed [fcalc_pkg::ACC_W-1:0]    accumulator,
  output logic [fcalc_pkg::OP_W-1:0]            pending_operator
);
  import fcalc_pkg::*;

  localparam int DW = (4 * DISPLAY_CHARS > ACC_W) ? 4 * DISPLAY_CHARS : ACC_W;
  localparam int MAXLEN = (DISPLAY_CHARS > 11) ? DISPLAY_CHARS : 11;
  localparam int LW = $clog2(MAXLEN + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]         state;
  logic [4:0]         cnt;
  logic signed [DW-1:0] disp;
  logic [LW-1:0]      dlen;
  logic [ACC_W-1:0]   acc;
  logic [OP_W-1:0]    op;
  logic               fresh;
  logic [ACC_W-1:0]   ra;
  logic [ACC_W-1:0]   rb;
  logic [ACC_W-1:0]   rp;
  logic               negq;

  logic [ACC_W-1:0]   v;
  logic [ACC_W-1:0]   mag;
  logic [DW-1:0]      disp_x10;
  logic [DW-1:0]      dig_w;
  logic [ACC_W-1:0]   mul_sum;
  logic [ACC_W:0]     div_t;
  logic [ACC_W:0]     div_d;
  logic               div_ge;
  logic [ACC_W-1:0]   q_next;
  logic               out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign v        = disp[ACC_W-1:0];
  assign mag      = acc[ACC_W-1] ? (~acc + 32'd1) : acc;
  assign disp_x10 = (DW'(disp) << 3) + (DW'(disp) << 1);
  assign dig_w    = DW'(digit);
  assign mul_sum  = rb[0] ? (rp + ra) : rp;
  assign div_t    = {rp, ra[ACC_W-1]};
  assign div_d    = div_t - {1'b0, rb};
  assign div_ge   = !div_d[ACC_W];
  assign q_next   = {ra[ACC_W-2:0], div_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      disp      <= '0;
      dlen      <= LW'(1);
      acc       <= '0;
      op        <= OP_NONE;
      fresh     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (!out_stall && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (func)
              KEY_DIGIT: begin
                state <= S_FIN;
                if (digit <= 4'd9) begin
                  if (fresh || (disp == '0 && dlen == LW'(1))) begin
                    disp  <= signed'(dig_w);
                    dlen  <= LW'(1);
                    fresh <= 1'b0;
                  end else if (dlen < LW'(DISPLAY_CHARS)) begin
                    disp <= disp[DW-1] ? signed'(disp_x10 - dig_w)
                                       : signed'(disp_x10 + dig_w);
                    dlen <= dlen + LW'(1);
                  end
                end
              end
              KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV, KEY_EQUALS: begin
                op    <= (func == KEY_EQUALS) ? OP_NONE : func;
                fresh <= 1'b1;
                cnt   <= '0;
                if (op != OP_NONE && !fresh) begin
                  case (op)
                    KEY_ADD: begin
                      acc   <= acc + v;
                      state <= S_LEN;
                    end
                    KEY_SUB: begin
                      acc   <= acc - v;
                      state <= S_LEN;
                    end
                    KEY_MUL: begin
                      ra    <= acc;
                      rb    <= v;
                      rp    <= '0;
                      state <= S_MUL;
                    end
                    KEY_DIV: begin
                      if (v != '0) begin
                        ra    <= mag;
                        rb    <= v[ACC_W-1] ? (~v + 32'd1) : v;
                        rp    <= '0;
                        negq  <= acc[ACC_W-1] ^ v[ACC_W-1];
                        state <= S_DIV;
                      end else begin
                        state <= S_LEN;
                      end
                    end
                    default: state <= S_LEN;
                  endcase
                end else begin
                  acc   <= v;
                  state <= S_LEN;
                end
              end
              KEY_CLEAR: begin
                disp  <= '0;
                dlen  <= LW'(1);
                acc   <= '0;
                op    <= OP_NONE;
                fresh <= 1'b1;
                state <= S_FIN;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_MUL: begin
          rp  <= mul_sum;
          ra  <= {ra[ACC_W-2:0], 1'b0};
          rb  <= {1'b0, rb[ACC_W-1:1]};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            acc   <= mul_sum;
            state <= S_LEN;
          end
        end
        S_DIV: begin
          rp  <= div_ge ? div_d[ACC_W-1:0] : div_t[ACC_W-1:0];
          ra  <= q_next;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            acc   <= negq ? (~q_next + 32'd1) : q_next;
            state <= S_LEN;
          end
        end
        S_LEN: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd0) begin
            dlen <= acc[ACC_W-1] ? LW'(2) : LW'(1);
          end else if (mag >= pow10(cnt[3:0])) begin
            dlen <= dlen + LW'(1);
          end
          if (cnt == 5'd9) begin
            disp  <= DW'(signed'(acc));
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            display_value    <= DVAL_W'(disp);
            display_length   <= DLEN_W'(dlen);
            accumulator      <= acc;
            pending_operator <= op;
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/fcalc_checker.sv
// Port-level checker for the calculator keypad, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fcalc_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [fcalc_pkg::DLEN_W-1:0]         display_length,
  input logic signed [fcalc_pkg::ACC_W-1:0]   accumulator,
  input logic [fcalc_pkg::OP_W-1:0]           pending_operator
);
  `CHK_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)
  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(accumulator))
  `CHK_IMPL(a_op_range, out_valid, pending_operator <= 3'd4)
  `CHK_IMPL(a_len_nonzero, out_valid, display_length != 4'd0)
endmodule

bind four_function_calculator_keypad fcalc_checker u_fcalc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .display_length(display_length),
  .accumulator(accumulator), .pending_operator(pending_operator)
);
